@@ rtl/core/sci_pkg.sv @@
// Shared constants, codes and types of the substitution count iterator.
`timescale 1ns / 1ps
package sci_pkg;

    localparam int MAX_SYMBOLS = 16;
    localparam int COUNT_BITS  = 48;
    localparam int SYM_W       = $clog2(MAX_SYMBOLS);
    localparam int NUM_W       = $clog2(MAX_SYMBOLS + 1);
    localparam int WEIGHT_W    = 5;
    localparam int REQ_W       = 2;
    localparam int INDEX_W     = 4;
    localparam int FIELD_W     = 48;
    localparam int USE_W       = 5;
    localparam int PADDR_W     = 4;
    localparam int PDATA_W     = 64;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    localparam logic [REQ_W-1:0] REQ_WRITE   = 2'd0;
    localparam logic [REQ_W-1:0] REQ_RESTART = 2'd1;
    localparam logic [REQ_W-1:0] REQ_STEP    = 2'd2;

    localparam logic REG_SYMBOLS_IN_USE = 1'b0;
    localparam logic REG_TOTAL_LIMIT    = 1'b1;

    typedef enum logic [2:0] {
        OP_HOLD,
        OP_WRITE,
        OP_RESTART,
        OP_START,
        OP_MAC,
        OP_FINISH
    } t_cell_op;

    typedef struct packed {
        t_cell_op              op;
        logic [SYM_W-1:0]      row;
        logic [SYM_W-1:0]      col;
        logic [WEIGHT_W-1:0]   weight;
        logic [SYM_W-1:0]      t;
        logic [NUM_W-1:0]      n;
    } t_cell_ctl;

endpackage

@@ rtl/core/sci_cell.sv @@
// One cell of the chain: a row of weights, one count and its multiply-accumulate.
`timescale 1ns / 1ps
module sci_cell (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  sci_pkg::t_cell_ctl             i_ctl,
    input  logic [sci_pkg::SYM_W-1:0]      i_cell_idx,
    input  logic [sci_pkg::COUNT_BITS-1:0] i_ring,
    output logic [sci_pkg::COUNT_BITS-1:0] o_count,
    output logic                           o_ovf
);
    import sci_pkg::*;

    localparam int PROD_W = COUNT_BITS + WEIGHT_W;

    logic [WEIGHT_W-1:0]   r_w [MAX_SYMBOLS];
    logic [COUNT_BITS-1:0] r_cnt;
    logic [COUNT_BITS-1:0] r_acc;
    logic [COUNT_BITS-1:0] r_prod;
    logic                  r_ovf;

    logic [SYM_W:0]        w_col_sum;
    logic [SYM_W-1:0]      w_col;
    logic                  w_row_act;
    logic                  w_act;
    logic [PROD_W-1:0]     w_prod_full;
    logic                  w_mul_sat;
    logic [COUNT_BITS-1:0] w_prod;
    logic [COUNT_BITS:0]   w_sum_full;
    logic                  w_add_sat;
    logic [COUNT_BITS-1:0] w_sum;
    logic [COUNT_BITS-1:0] w_unit;

    // At ring step t this cell holds the count of symbol (index + t) mod MAX_SYMBOLS.
    assign w_col_sum = {1'b0, i_cell_idx} + {1'b0, i_ctl.t};
    assign w_col     = (w_col_sum >= (SYM_W+1)'(MAX_SYMBOLS))
                     ? SYM_W'(w_col_sum - (SYM_W+1)'(MAX_SYMBOLS))
                     : w_col_sum[SYM_W-1:0];

    assign w_row_act = NUM_W'(i_cell_idx) < i_ctl.n;
    assign w_act     = w_row_act && (NUM_W'(w_col) < i_ctl.n);

    assign w_prod_full = PROD_W'(r_cnt) * PROD_W'(r_w[w_col]);
    assign w_mul_sat   = |w_prod_full[PROD_W-1:COUNT_BITS];
    assign w_prod      = w_mul_sat ? COUNT_MAX : w_prod_full[COUNT_BITS-1:0];

    assign w_sum_full = {1'b0, r_acc} + {1'b0, r_prod};
    assign w_add_sat  = w_sum_full[COUNT_BITS];
    assign w_sum      = w_add_sat ? COUNT_MAX : w_sum_full[COUNT_BITS-1:0];

    assign w_unit = (i_cell_idx == '0) ? COUNT_BITS'(1) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= w_unit;
            r_ovf <= 1'b0;
            for (int k = 0; k < MAX_SYMBOLS; k++) begin
                r_w[k] <= '0;
            end
        end else begin
            unique case (i_ctl.op)
                OP_WRITE: begin
                    if (i_ctl.row == i_cell_idx) begin
                        r_w[i_ctl.col] <= i_ctl.weight;
                    end
                end
                OP_RESTART: begin
                    r_cnt <= w_unit;
                    r_ovf <= 1'b0;
                end
                OP_START: begin
                    r_acc  <= '0;
                    r_prod <= '0;
                    r_ovf  <= 1'b0;
                end
                OP_MAC: begin
                    r_cnt  <= i_ring;
                    r_prod <= w_act ? w_prod : '0;
                    r_acc  <= w_sum;
                    r_ovf  <= r_ovf | (w_act & w_mul_sat) | w_add_sat;
                end
                OP_FINISH: begin
                    r_cnt <= w_row_act ? w_sum : '0;
                    r_ovf <= r_ovf | (w_row_act & w_add_sat);
                end
                OP_HOLD: begin
                end
                default: begin
                end
            endcase
        end
    end

    assign o_count = r_cnt;
    assign o_ovf   = r_ovf;

endmodule

@@ rtl/core/substitution_count_iterator.sv @@
// Top level of the substitution count iterator: control, totals, output register and APB port.
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+---------------------------------------------
//  request  | in        | i_valid / o_stall | i_req_type i_row_index i_col_index i_weight
//  result   | out       | o_valid / i_stall | o_symbol_index o_symbol_count o_total_count
//           |           |                   | o_limit_reached o_overflow o_is_last
//  config   | in        | APB psel/penable  | paddr pwdata prdata pready
//
// A step runs through the cell chain (a full ring rotation with one multiply-accumulate per
// cell at each shift, then one finishing add), then totals the counts and hands out the n
// result words; a restart skips the chain.
// The weight store and the count vector are set by the synchronous reset at once.
// A stalled result word holds in the output register; the block takes the next request
// once the last word of a generation has entered that register.
`timescale 1ns / 1ps
module substitution_count_iterator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic [sci_pkg::REQ_W-1:0]       i_req_type,
    input  logic [sci_pkg::INDEX_W-1:0]     i_row_index,
    input  logic [sci_pkg::INDEX_W-1:0]     i_col_index,
    input  logic [sci_pkg::WEIGHT_W-1:0]    i_weight,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [sci_pkg::INDEX_W-1:0]     o_symbol_index,
    output logic [sci_pkg::FIELD_W-1:0]     o_symbol_count,
    output logic [sci_pkg::FIELD_W-1:0]     o_total_count,
    output logic                            o_limit_reached,
    output logic                            o_overflow,
    output logic                            o_is_last,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [sci_pkg::PADDR_W-1:0]     paddr,
    input  logic [sci_pkg::PDATA_W-1:0]     pwdata,
    output logic [sci_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready
);
    import sci_pkg::*;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MAC    = 3'd1;
    localparam logic [2:0] ST_FINISH = 3'd2;
    localparam logic [2:0] ST_SUM    = 3'd3;
    localparam logic [2:0] ST_EMIT   = 3'd4;

    logic [2:0]            r_state;
    logic [2:0]            n_state;
    logic [SYM_W-1:0]      r_t;
    logic [SYM_W-1:0]      n_t;
    logic [SYM_W-1:0]      r_i;
    logic [SYM_W-1:0]      n_i;
    logic [COUNT_BITS-1:0] r_total;
    logic                  r_gen_ovf;
    logic [USE_W-1:0]      r_sym_use;
    logic [FIELD_W-1:0]    r_total_limit;

    logic                  r_o_valid;
    logic [INDEX_W-1:0]    r_o_index;
    logic [FIELD_W-1:0]    r_o_count;
    logic [FIELD_W-1:0]    r_o_total;
    logic                  r_o_limit;
    logic                  r_o_ovf;
    logic                  r_o_last;

    t_cell_ctl             w_ctl;
    logic [COUNT_BITS-1:0] w_cnt [MAX_SYMBOLS];
    logic [MAX_SYMBOLS-1:0] w_ovf;
    logic [NUM_W-1:0]      w_n;
    logic                  w_in_acc;
    logic                  w_wr_ok;
    logic                  w_cfg_wr;
    logic                  w_last;
    logic                  w_out_load;
    logic [COUNT_BITS-1:0] w_sel_cnt;
    logic [COUNT_BITS:0]   w_tot_full;
    logic                  w_tot_sat;
    logic [COUNT_BITS-1:0] w_tot;

    // The chain of cells; each one passes its count to the cell below, in a ring.
    for (genvar g = 0; g < MAX_SYMBOLS; g++) begin : g_cell
        sci_cell u_cell (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (w_ctl),
            .i_cell_idx (SYM_W'(g)),
            .i_ring     (w_cnt[(g + 1) % MAX_SYMBOLS]),
            .o_count    (w_cnt[g]),
            .o_ovf      (w_ovf[g])
        );
    end

    always_comb begin
        if (r_sym_use == '0) begin
            w_n = NUM_W'(1);
        end else if (32'(r_sym_use) > MAX_SYMBOLS) begin
            w_n = NUM_W'(MAX_SYMBOLS);
        end else begin
            w_n = NUM_W'(r_sym_use);
        end
    end

    assign o_stall    = (r_state != ST_IDLE);
    assign w_in_acc   = i_valid && !o_stall;
    assign w_wr_ok    = (32'(i_row_index) < MAX_SYMBOLS) && (32'(i_col_index) < MAX_SYMBOLS);
    assign w_last     = (NUM_W'(r_i) + NUM_W'(1)) == w_n;
    assign w_out_load = (r_state == ST_EMIT) && (!r_o_valid || !i_stall);

    assign w_sel_cnt  = w_cnt[r_i];
    assign w_tot_full = {1'b0, r_total} + {1'b0, w_sel_cnt};
    assign w_tot_sat  = w_tot_full[COUNT_BITS];
    assign w_tot      = w_tot_sat ? COUNT_MAX : w_tot_full[COUNT_BITS-1:0];

    always_comb begin
        n_state    = r_state;
        n_t        = r_t;
        n_i        = r_i;
        w_ctl.op   = OP_HOLD;
        w_ctl.row  = SYM_W'(i_row_index);
        w_ctl.col  = SYM_W'(i_col_index);
        w_ctl.weight = i_weight;
        w_ctl.t    = r_t;
        w_ctl.n    = w_n;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    unique case (i_req_type)
                        REQ_WRITE: begin
                            if (w_wr_ok) begin
                                w_ctl.op = OP_WRITE;
                            end
                        end
                        REQ_RESTART: begin
                            w_ctl.op = OP_RESTART;
                            n_state  = ST_SUM;
                            n_i      = '0;
                        end
                        REQ_STEP: begin
                            w_ctl.op = OP_START;
                            n_state  = ST_MAC;
                            n_t      = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_MAC: begin
                w_ctl.op = OP_MAC;
                if (r_t == SYM_W'(MAX_SYMBOLS - 1)) begin
                    n_state = ST_FINISH;
                end else begin
                    n_t = r_t + SYM_W'(1);
                end
            end
            ST_FINISH: begin
                w_ctl.op = OP_FINISH;
                n_state  = ST_SUM;
                n_i      = '0;
            end
            ST_SUM: begin
                if (w_last) begin
                    n_state = ST_EMIT;
                    n_i     = '0;
                end else begin
                    n_i = r_i + SYM_W'(1);
                end
            end
            ST_EMIT: begin
                if (w_out_load) begin
                    if (w_last) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_i = r_i + SYM_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_t           <= '0;
            r_i           <= '0;
            r_o_valid     <= 1'b0;
            r_sym_use     <= USE_W'(1);
            r_total_limit <= '0;
        end else begin
            r_state <= n_state;
            r_t     <= n_t;
            r_i     <= n_i;
            if (w_out_load) begin
                r_o_valid <= 1'b1;
            end else if (!i_stall) begin
                r_o_valid <= 1'b0;
            end
            if (w_cfg_wr) begin
                if (paddr[3] == REG_SYMBOLS_IN_USE) begin
                    r_sym_use <= pwdata[USE_W-1:0];
                end else begin
                    r_total_limit <= pwdata[FIELD_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_state == ST_SUM && r_state != ST_SUM) begin
            r_total   <= '0;
            r_gen_ovf <= 1'b0;
        end else if (r_state == ST_SUM) begin
            r_total   <= w_tot;
            r_gen_ovf <= r_gen_ovf | w_tot_sat | (|w_ovf);
        end
        if (w_out_load) begin
            r_o_index <= INDEX_W'(r_i);
            r_o_count <= FIELD_W'(w_sel_cnt);
            r_o_total <= w_last ? FIELD_W'(r_total) : '0;
            r_o_limit <= w_last && (FIELD_W'(r_total) >= r_total_limit);
            r_o_ovf   <= r_gen_ovf;
            r_o_last  <= w_last;
        end
    end

    assign o_valid         = r_o_valid;
    assign o_symbol_index  = r_o_index;
    assign o_symbol_count  = r_o_count;
    assign o_total_count   = r_o_total;
    assign o_limit_reached = r_o_limit;
    assign o_overflow      = r_o_ovf;
    assign o_is_last       = r_o_last;

    assign pready = 1'b1;
    assign prdata = (paddr[3] == REG_TOTAL_LIMIT) ? PDATA_W'(r_total_limit)
                                                  : PDATA_W'(r_sym_use);

    a_step_enters_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && i_req_type == REQ_STEP) |=> (r_state == ST_MAC))
        else $error("Accepted step did not start the cell chain.");

    a_total_on_last_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_is_last) |-> (o_total_count == '0 && !o_limit_reached))
        else $error("Total or limit flag shown on a word that is not the last.");

    a_finish_after_mac: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_FINISH) |-> ($past(r_state) == ST_MAC
                                    && $past(r_t) == SYM_W'(MAX_SYMBOLS - 1)))
        else $error("Finishing add reached without a full ring rotation.");

endmodule

@@ dv/tb_top.sv @@
// Self-checking testbench for the substitution count iterator: directed and random request words.
`timescale 1ns / 1ps
module tb_top;
    import sci_pkg::*;

    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES = 60;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS = 50;

    typedef struct packed {
        logic [INDEX_W-1:0] sym;
        logic [FIELD_W-1:0] count;
        logic [FIELD_W-1:0] total;
        logic               limit_hit;
        logic               ovf;
        logic               last;
    } t_count_word;

    logic                   i_clk;
    logic                   i_rst_n = 1'b0;
    logic                   i_valid = 1'b0;
    logic                   o_stall;
    logic [REQ_W-1:0]       i_req_type = '0;
    logic [INDEX_W-1:0]     i_row_index = '0;
    logic [INDEX_W-1:0]     i_col_index = '0;
    logic [WEIGHT_W-1:0]    i_weight = '0;
    logic                   o_valid;
    logic                   i_stall = 1'b0;
    logic [INDEX_W-1:0]     o_symbol_index;
    logic [FIELD_W-1:0]     o_symbol_count;
    logic [FIELD_W-1:0]     o_total_count;
    logic                   o_limit_reached;
    logic                   o_overflow;
    logic                   o_is_last;
    logic                   psel = 1'b0;
    logic                   penable = 1'b0;
    logic                   pwrite = 1'b0;
    logic [PADDR_W-1:0]     paddr = '0;
    logic [PDATA_W-1:0]     pwdata = '0;
    logic [PDATA_W-1:0]     prdata;
    logic                   pready;

    substitution_count_iterator dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_valid),
        .o_stall(o_stall),
        .i_req_type(i_req_type),
        .i_row_index(i_row_index),
        .i_col_index(i_col_index),
        .i_weight(i_weight),
        .o_valid(o_valid),
        .i_stall(i_stall),
        .o_symbol_index(o_symbol_index),
        .o_symbol_count(o_symbol_count),
        .o_total_count(o_total_count),
        .o_limit_reached(o_limit_reached),
        .o_overflow(o_overflow),
        .o_is_last(o_is_last),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    logic [WEIGHT_W-1:0]   model_weight [MAX_SYMBOLS][MAX_SYMBOLS];
    logic [COUNT_BITS-1:0] model_count [MAX_SYMBOLS];
    logic [USE_W-1:0]      model_symbols;
    logic [FIELD_W-1:0]    model_limit;
    bit                    gen_ovf;
    t_count_word           pending_counts [$];

    bit steady_flow = 1'b0;
    int mismatch_count = 0;
    int words_sent = 0;
    int words_checked = 0;
    int overflow_words = 0;
    int limit_words = 0;
    int result_stall_left = 0;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #4_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int active_symbols();
        if (model_symbols == 0)
            return 1;
        if (model_symbols > MAX_SYMBOLS)
            return MAX_SYMBOLS;
        return model_symbols;
    endfunction

    function automatic logic [63:0] add_sat(logic [63:0] a, logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (s > COUNT_MAX) begin
            gen_ovf = 1'b1;
            return COUNT_MAX;
        end
        return s;
    endfunction

    function automatic logic [63:0] mul_sat(logic [63:0] a, logic [63:0] w);
        logic [63:0] p;
        p = a * w;
        if (p > COUNT_MAX) begin
            gen_ovf = 1'b1;
            return COUNT_MAX;
        end
        return p;
    endfunction

    task automatic reset_model();
        for (int r = 0; r < MAX_SYMBOLS; r++) begin
            for (int c = 0; c < MAX_SYMBOLS; c++)
                model_weight[r][c] = '0;
            model_count[r] = '0;
        end
        model_count[0] = COUNT_BITS'(1);
        model_symbols = USE_W'(1);
        model_limit = '0;
    endtask

    // Queues one word per active symbol; the total may saturate and raise overflow too.
    task automatic emit_counts();
        logic [63:0] total;
        t_count_word cw;
        int n;
        n = active_symbols();
        total = '0;
        for (int j = 0; j < n; j++)
            total = add_sat(total, model_count[j]);
        for (int j = 0; j < n; j++) begin
            cw.sym = j[INDEX_W-1:0];
            cw.count = model_count[j];
            cw.last = (j == n - 1);
            cw.total = cw.last ? total[FIELD_W-1:0] : '0;
            cw.limit_hit = cw.last && (total >= model_limit);
            cw.ovf = gen_ovf;
            pending_counts.push_back(cw);
        end
    endtask

    task automatic advance_counts(input logic [REQ_W-1:0] req, input logic [INDEX_W-1:0] row,
                                  input logic [INDEX_W-1:0] col,
                                  input logic [WEIGHT_W-1:0] w);
        logic [COUNT_BITS-1:0] next_count [MAX_SYMBOLS];
        logic [63:0] acc;
        int n;
        n = active_symbols();
        case (req)
            REQ_WRITE: begin
                model_weight[row][col] = w;
            end
            REQ_RESTART: begin
                for (int j = 0; j < MAX_SYMBOLS; j++)
                    model_count[j] = '0;
                model_count[0] = COUNT_BITS'(1);
                gen_ovf = 1'b0;
                emit_counts();
            end
            REQ_STEP: begin
                gen_ovf = 1'b0;
                for (int j = 0; j < MAX_SYMBOLS; j++) begin
                    acc = '0;
                    if (j < n) begin
                        for (int k = 0; k < n; k++)
                            acc = add_sat(acc, mul_sat(model_count[k], model_weight[j][k]));
                    end
                    next_count[j] = acc[COUNT_BITS-1:0];
                end
                for (int j = 0; j < MAX_SYMBOLS; j++)
                    model_count[j] = next_count[j];
                emit_counts();
            end
            default: begin
            end
        endcase
    endtask

    task automatic show_mismatch(input string what, input t_count_word want,
                                 input t_count_word got);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("%0t: %s", $realtime, what);
            $display("    expected sym %0d count %0d total %0d limit %0b ovf %0b last %0b",
                     want.sym, want.count, want.total, want.limit_hit, want.ovf, want.last);
            $display("    actual   sym %0d count %0d total %0d limit %0b ovf %0b last %0b",
                     got.sym, got.count, got.total, got.limit_hit, got.ovf, got.last);
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_count_word got;
        t_count_word want;
        got = {o_symbol_index, o_symbol_count, o_total_count, o_limit_reached, o_overflow,
               o_is_last};
        if (!i_rst_n) begin
            result_stall_left = 0;
            i_stall <= 1'b0;
        end else if (o_valid && !i_stall) begin
            words_checked++;
            if (got.ovf === 1'b1)
                overflow_words++;
            if (got.limit_hit === 1'b1)
                limit_words++;
            if (pending_counts.size() == 0) begin
                show_mismatch("result word with nothing expected", got, got);
            end else begin
                want = pending_counts.pop_front();
                if (got.sym !== want.sym || got.count !== want.count ||
                    got.total !== want.total || got.limit_hit !== want.limit_hit ||
                    got.ovf !== want.ovf || got.last !== want.last)
                    show_mismatch("result word mismatch", want, got);
            end
            result_stall_left = steady_flow ? 0 : $urandom_range(0, 18);
            i_stall <= (result_stall_left != 0);
        end else begin
            if (result_stall_left != 0)
                result_stall_left--;
            i_stall <= (result_stall_left != 0);
        end
    end

    task automatic send_word(input logic [REQ_W-1:0] req, input logic [INDEX_W-1:0] row,
                             input logic [INDEX_W-1:0] col, input logic [WEIGHT_W-1:0] w);
        int gap;
        gap = steady_flow ? 0 : $urandom_range(0, 18);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req_type <= req;
        i_row_index <= row;
        i_col_index <= col;
        i_weight <= w;
        @(posedge i_clk);
        while (o_stall)
            @(posedge i_clk);
        advance_counts(req, row, col, w);
        words_sent++;
    endtask

    task automatic wait_drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_counts.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic set_register(input logic reg_index, input logic [63:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {reg_index, 3'b000};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (reg_index == REG_SYMBOLS_IN_USE)
            model_symbols = value[USE_W-1:0];
        else
            model_limit = value[FIELD_W-1:0];
    endtask

    // Upper data bits carry noise that the registers must drop.
    task automatic configure(input logic [USE_W-1:0] symbols, input logic [FIELD_W-1:0] limit);
        logic [63:0] noise;
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        noise = {$urandom, $urandom};
        set_register(REG_SYMBOLS_IN_USE, {noise[63:USE_W], symbols});
        set_register(REG_TOTAL_LIMIT, {noise[63:FIELD_W], limit});
    endtask

    function automatic logic [FIELD_W-1:0] random_limit();
        logic [63:0] r;
        r = {$urandom, $urandom};
        case ($urandom_range(0, 3))
            0: return '0;
            1: return COUNT_MAX;
            2: return FIELD_W'($urandom_range(1, 2000));
            default: return r[FIELD_W-1:0];
        endcase
    endfunction

    function automatic logic [USE_W-1:0] random_symbols();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return USE_W'($urandom_range(MAX_SYMBOLS + 1, 31));
            2: return USE_W'(MAX_SYMBOLS);
            3: return USE_W'(1);
            default: return USE_W'($urandom_range(2, 8));
        endcase
    endfunction

    task automatic test_defaults();
        send_word(REQ_RESTART, 4'd0, 4'd0, 5'd0);
        send_word(REQ_STEP, 4'd0, 4'd0, 5'd0);
        send_word(REQ_UNUSED, 4'd15, 4'd15, 5'd31);
        send_word(REQ_WRITE, 4'd15, 4'd15, 5'd31);
    endtask

    task automatic test_two_symbol_growth();
        configure(5'd2, 48'd3);
        send_word(REQ_WRITE, 4'd0, 4'd0, 5'd1);
        send_word(REQ_WRITE, 4'd0, 4'd1, 5'd1);
        send_word(REQ_WRITE, 4'd1, 4'd0, 5'd1);
        send_word(REQ_RESTART, 4'd0, 4'd0, 5'd0);
        send_word(REQ_STEP, 4'd0, 4'd0, 5'd0);
        send_word(REQ_STEP, 4'd0, 4'd0, 5'd0);
    endtask

    task automatic test_full_vector();
        configure(USE_W'(MAX_SYMBOLS), COUNT_MAX);
        send_word(REQ_WRITE, 4'd15, 4'd0, 5'd31);
        send_word(REQ_RESTART, 4'd0, 4'd0, 5'd0);
        send_word(REQ_STEP, 4'd0, 4'd0, 5'd0);
    endtask

    task automatic test_symbols_out_of_range();
        configure(5'd0, 48'd0);
        send_word(REQ_STEP, 4'd0, 4'd0, 5'd0);
        configure(5'd31, 48'd1);
        send_word(REQ_RESTART, 4'd0, 4'd0, 5'd0);
    endtask

    task automatic test_saturation();
        configure(5'd2, COUNT_MAX);
        send_word(REQ_WRITE, 4'd0, 4'd0, 5'd31);
        send_word(REQ_WRITE, 4'd0, 4'd1, 5'd31);
        send_word(REQ_WRITE, 4'd1, 4'd1, 5'd31);
        send_word(REQ_RESTART, 4'd0, 4'd0, 5'd0);
        steady_flow = 1'b1;
        repeat (10)
            send_word(REQ_STEP, 4'd0, 4'd0, 5'd0);
        steady_flow = 1'b0;
    endtask

    // Each phase opens with a restart, then mixes weight writes, steps, a few restarts and unused codes.
    task automatic test_random_generations();
        int taken;
        int pick;
        logic [WEIGHT_W-1:0] w;
        for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
            configure(random_symbols(), random_limit());
            steady_flow = (phase == 3);
            send_word(REQ_RESTART, INDEX_W'($urandom_range(0, 15)),
                      INDEX_W'($urandom_range(0, 15)), WEIGHT_W'($urandom_range(0, 31)));
            taken = 1;
            while (taken < PHASE_ITEMS) begin
                if (phase == 5 && taken == PHASE_ITEMS / 2)
                    wait_drain();
                pick = $urandom_range(0, 99);
                w = ($urandom_range(0, 3) == 0) ? WEIGHT_W'($urandom_range(0, 31))
                                                : WEIGHT_W'($urandom_range(0, 2));
                if (pick < 40) begin
                    send_word(REQ_WRITE, INDEX_W'($urandom_range(0, 15)),
                              INDEX_W'($urandom_range(0, 15)), w);
                    taken++;
                end else if (pick < 50) begin
                    send_word(REQ_RESTART, INDEX_W'($urandom_range(0, 15)),
                              INDEX_W'($urandom_range(0, 15)), w);
                    taken++;
                end else if (pick < 95) begin
                    send_word(REQ_STEP, INDEX_W'($urandom_range(0, 15)),
                              INDEX_W'($urandom_range(0, 15)), w);
                    taken++;
                end else begin
                    send_word(REQ_UNUSED, INDEX_W'($urandom_range(0, 15)),
                              INDEX_W'($urandom_range(0, 15)), w);
                end
            end
            steady_flow = 1'b0;
        end
    endtask

    initial begin
        reset_model();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_defaults();
        test_two_symbol_growth();
        test_full_vector();
        test_symbols_out_of_range();
        test_saturation();
        test_random_generations();
        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (pending_counts.size() != 0) begin
            mismatch_count += pending_counts.size();
            $display("%0d expected result words never arrived", pending_counts.size());
        end
        $display("Sent %0d request words and checked %0d result words.", words_sent,
                 words_checked);
        $display("Result words with overflow set: %0d, with limit reached: %0d.",
                 overflow_words, limit_words);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
